// File: hw/rtl/pct_pkg.sv
// ----------------------------------------------------------------------------
// pct_pkg: shared types and constants for the prefix count tree
// Command codes, controller states, field widths and the memory control group.
// ----------------------------------------------------------------------------
package pct_pkg;

  // Field widths of the command, result and configuration ports.
  localparam int COMMAND_W    = 2;
  localparam int POSITION_W   = 13;
  localparam int TABLE_SIZE_W = 13;
  localparam int COUNT_W      = 36;
  localparam int NODE_W       = 32;

  // Default number of tree nodes and the table size after reset.
  localparam int                  DEFAULT_MAX_POSITIONS = 4096;
  localparam logic [TABLE_SIZE_W-1:0] TABLE_SIZE_RESET  = 13'd4096;

  // Command codes.
  typedef enum logic [COMMAND_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_BELOW = 2'd1,
    CMD_UPTO  = 2'd2,
    CMD_CLEAR = 2'd3
  } pct_cmd_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_ADD   = 2'd1,
    ST_QUERY = 2'd2,
    ST_CLEAR = 2'd3
  } pct_state_t;

  // Enables for the node memory ports.
  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } pct_mem_ctl_t;

endpackage

// File: hw/rtl/pct_node_mem.sv
// ----------------------------------------------------------------------------
// pct_node_mem: node counter memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module pct_node_mem
  import pct_pkg::*;
#(
  parameter int DEPTH = DEFAULT_MAX_POSITIONS,
  parameter int AW    = $clog2(DEFAULT_MAX_POSITIONS)
) (
  input  logic              clk,
  input  pct_mem_ctl_t      ctl,
  input  logic [AW-1:0]     waddr,
  input  logic [NODE_W-1:0] wdata,
  input  logic [AW-1:0]     raddr,
  output logic [NODE_W-1:0] rdata_r
);

  logic [NODE_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; the read data is registered.
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// File: hw/rtl/pct_ctrl.sv
// ----------------------------------------------------------------------------
// pct_ctrl: tree walk controller
// Walks the tree one node per cycle with reads issued ahead of write-back,
// accumulates query sums and sweeps the memory on clear and after reset.
// ----------------------------------------------------------------------------
module pct_ctrl
  import pct_pkg::*;
#(
  parameter int MAX_POSITIONS = DEFAULT_MAX_POSITIONS,
  parameter int AW            = $clog2(DEFAULT_MAX_POSITIONS)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [COMMAND_W-1:0]    in_command,
  input  logic [POSITION_W-1:0]   in_position,
  input  logic [TABLE_SIZE_W-1:0] table_size,
  output logic                    out_strobe,
  output logic [COUNT_W-1:0]      out_count,
  output pct_mem_ctl_t            mem_ctl,
  output logic [AW-1:0]           mem_waddr,
  output logic [NODE_W-1:0]       mem_wdata,
  output logic [AW-1:0]           mem_raddr,
  input  logic [NODE_W-1:0]       mem_rdata
);

  // Node numbers need room for the table size and for one climb step past it.
  localparam int KBITS = $clog2(MAX_POSITIONS + 1);
  localparam int NW    = (KBITS > POSITION_W) ? KBITS + 1 : POSITION_W + 1;

  localparam logic [NW-1:0] MAX_NODES = NW'(MAX_POSITIONS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_POSITIONS - 1);

  pct_state_t         state_r, state_nxt;
  logic [NW-1:0]      k_r, k_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic [AW-1:0]      prev_addr_r, prev_addr_nxt;
  logic [COUNT_W-1:0] acc_r, acc_nxt;
  logic [AW-1:0]      clr_addr_r, clr_addr_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  logic [COUNT_W-1:0] out_count_r, out_count_nxt;

  pct_cmd_t      cmd;
  logic [NW-1:0] pos_ext;
  logic [NW-1:0] n_cur;
  logic [NW-1:0] low_bit;
  logic [AW-1:0] node_addr;
  logic          issue;
  logic          walk_done;

  assign cmd     = pct_cmd_t'(in_command);
  assign pos_ext = NW'(in_position);

  // Active node count: table size limited to the memory depth.
  assign n_cur = (NW'(table_size) > MAX_NODES) ? MAX_NODES : NW'(table_size);

  // Lowest set bit of the current node number and its memory address.
  assign low_bit   = k_r & NW'(~k_r + NW'(1));
  assign node_addr = AW'(k_r - NW'(1));

  // A node is read while the walk still has a node in range.
  assign issue = (k_r != '0) &&
                 ((state_r == ST_QUERY) || ((state_r == ST_ADD) && (k_r <= n_r)));
  assign walk_done = !issue && !rd_pend_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          unique case (cmd)
            CMD_ADD:   state_nxt = ST_ADD;
            CMD_BELOW: state_nxt = ST_QUERY;
            CMD_UPTO:  state_nxt = ST_QUERY;
            CMD_CLEAR: state_nxt = ST_CLEAR;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        if (walk_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_QUERY: begin
        if (walk_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs toward the command port and the memory.
  always_comb begin
    busy           = (state_r != ST_IDLE);
    mem_ctl.rd_en  = issue;
    mem_ctl.wr_en  = (state_r == ST_CLEAR) || ((state_r == ST_ADD) && rd_pend_r);
    mem_raddr      = node_addr;
    if (state_r == ST_CLEAR) begin
      mem_waddr = clr_addr_r;
      mem_wdata = '0;
    end else begin
      mem_waddr = prev_addr_r;
      mem_wdata = mem_rdata + NODE_W'(1);
    end
  end

  // Walk datapath: node number, pending read, sum and clear sweep.
  always_comb begin
    k_nxt          = k_r;
    n_nxt          = n_r;
    rd_pend_nxt    = issue;
    prev_addr_nxt  = issue ? node_addr : prev_addr_r;
    acc_nxt        = acc_r;
    clr_addr_nxt   = clr_addr_r;
    out_strobe_nxt = 1'b0;
    out_count_nxt  = out_count_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          n_nxt        = n_cur;
          acc_nxt      = '0;
          clr_addr_nxt = '0;
          unique case (cmd)
            CMD_ADD:   k_nxt = pos_ext + NW'(1);
            CMD_BELOW: k_nxt = (pos_ext > n_cur) ? n_cur : pos_ext;
            CMD_UPTO:  k_nxt = (pos_ext >= n_cur) ? n_cur : pos_ext + NW'(1);
            CMD_CLEAR: k_nxt = '0;
            default:   k_nxt = '0;
          endcase
        end
      end
      ST_ADD: begin
        if (issue) begin
          k_nxt = k_r + low_bit;
        end
      end
      ST_QUERY: begin
        if (issue) begin
          k_nxt = k_r - low_bit;
        end
        if (rd_pend_r) begin
          acc_nxt = acc_r + COUNT_W'(mem_rdata);
        end
        if (walk_done) begin
          out_strobe_nxt = 1'b1;
          out_count_nxt  = acc_r;
        end
      end
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + AW'(1);
      end
      default: begin
        k_nxt = k_r;
      end
    endcase
  end

  // Control registers; the memory is swept clean after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      rd_pend_r    <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_addr_r   <= clr_addr_nxt;
      rd_pend_r    <= rd_pend_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    k_r         <= k_nxt;
    n_r         <= n_nxt;
    prev_addr_r <= prev_addr_nxt;
    acc_r       <= acc_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_count  = out_count_r;

endmodule

// File: hw/rtl/prefix_count_tree_top.sv
// ----------------------------------------------------------------------------
// prefix_count_tree_top: binary indexed tree of occurrence counts
// Adds, prefix count queries and clears over a node counter memory.
// ----------------------------------------------------------------------------
//
//  Channel   Ports                                   Transaction
//  -------   -------------------------------------   ---------------------------
//  command   start, busy, in_command, in_position    start high while busy low
//  result    out_strobe, out_count                   one cycle with out_strobe
//  config    cfg_valid, cfg_ready, cfg_table_size    cfg_valid and cfg_ready high
//
//  An add or query holds busy while it issues one read per node visited, then
//  while the last read data returns, and then while it closes the walk; the
//  pace is set by the single read and write port pair of the node memory.
//  A new command is taken only once busy is low again.
//  A query's result is on out_strobe in the first cycle after busy falls.
//  Clear holds busy while it writes zero to every memory entry, one entry per
//  cycle, and the same clearing pass runs after reset. The receiver cannot
//  stall.
//
module prefix_count_tree_top
  import pct_pkg::*;
#(
  parameter int MAX_POSITIONS = DEFAULT_MAX_POSITIONS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [COMMAND_W-1:0]    in_command,
  input  logic [POSITION_W-1:0]   in_position,
  output logic                    out_strobe,
  output logic [COUNT_W-1:0]      out_count,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [TABLE_SIZE_W-1:0] cfg_table_size
);

  localparam int AW = $clog2(MAX_POSITIONS);

  logic [TABLE_SIZE_W-1:0] table_size_r;
  pct_mem_ctl_t            mem_ctl;
  logic [AW-1:0]           mem_waddr;
  logic [NODE_W-1:0]       mem_wdata;
  logic [AW-1:0]           mem_raddr;
  logic [NODE_W-1:0]       mem_rdata;

  // Table size register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_size_r <= TABLE_SIZE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      table_size_r <= cfg_table_size;
    end
  end

  // Walk controller.
  pct_ctrl #(
    .MAX_POSITIONS(MAX_POSITIONS),
    .AW           (AW)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_command (in_command),
    .in_position(in_position),
    .table_size (table_size_r),
    .out_strobe (out_strobe),
    .out_count  (out_count),
    .mem_ctl    (mem_ctl),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata)
  );

  // Node counter memory.
  pct_node_mem #(
    .DEPTH(MAX_POSITIONS),
    .AW   (AW)
  ) u_node_mem (
    .clk    (clk),
    .ctl    (mem_ctl),
    .waddr  (mem_waddr),
    .wdata  (mem_wdata),
    .raddr  (mem_raddr),
    .rdata_r(mem_rdata)
  );

endmodule
